// ===== src/a85_pkg.sv =====
`default_nettype none
package a85_pkg;

  localparam int unsigned GroupBytes  = 4;
  localparam int unsigned GroupDigits = 5;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [6:0] CharOffset = 7'd33;
  localparam logic [6:0] CharZero   = 7'h7A;
  localparam logic [6:0] CharLt     = 7'h3C;
  localparam logic [6:0] CharTilde  = 7'h7E;
  localparam logic [6:0] CharGt     = 7'h3E;
  localparam logic [6:0] Base       = 7'd85;

  // floor(v / 85) == (v * RecipBase) >> RecipShift for every 32-bit v
  localparam logic [31:0] RecipBase  = 32'd3233857729;
  localparam int unsigned RecipShift = 38;

  typedef enum logic [1:0] {
    K_NONE,
    K_ZERO,
    K_DIGITS
  } kind_e;

  typedef struct packed {
    logic        open_f;
    logic        close_f;
    kind_e       kind;
    logic [2:0]  cnt;
    logic [31:0] value;
  } job_t;

  typedef struct packed {
    logic            open_f;
    logic            close_f;
    kind_e           kind;
    logic [2:0]      cnt;
    logic [4:0][6:0] digits;
  } pkt_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_CALC,
    C_DONE
  } conv_state_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_OPEN0,
    E_OPEN1,
    E_BODY,
    E_CLOSE0,
    E_CLOSE1
  } emit_state_e;

endpackage
`default_nettype wire

// ===== src/ascii85_stream_encoder.sv =====
// channel   dir  tdata                          tlast
// s_axis    in   [7:0] data_byte                last_byte
// m_axis    out  [6:0] out_char, [7] zero       last_char on the closing '>'
//
// a byte is taken in the cycle it arrives while the four-entry job queue has room
// each job of kind K_DIGITS is converted in C_CALC, one base-85 digit per cycle
// from the reciprocal multiplier, then held in C_DONE until the emitter takes it;
// K_ZERO and K_NONE jobs skip C_CALC; output is one character per cycle while
// packets wait and m_axis_tready is high; each message adds four delimiters <~ ~>
// reset is asynchronous and active low; no clearing pass follows it
// output stalls back up through the emitter, converter and queue to s_axis_tready
`default_nettype none
module ascii85_stream_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [6:0] out_char, [7] zero
  output logic       m_axis_tlast
);
  import a85_pkg::*;

  logic       push;
  job_t       job_in;
  logic       q_ready;
  logic       q_valid;
  logic       q_pop;
  job_t       job_out;
  logic       pkt_valid;
  pkt_t       pkt;
  logic       pkt_take;
  logic [6:0] out_char;

  a85_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .data_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .push_o      (push),
    .job_o       (job_in),
    .job_ready_i (q_ready)
  );

  a85_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .job_o   (job_out)
  );

  a85_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (job_out),
    .job_pop_o   (q_pop),
    .pkt_valid_o (pkt_valid),
    .pkt_o       (pkt),
    .pkt_take_i  (pkt_take)
  );

  a85_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (pkt_valid),
    .pkt_i       (pkt),
    .pkt_take_o  (pkt_take),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready),
    .char_o      (out_char),
    .last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
`default_nettype wire

// ===== src/a85_front.sv =====
`default_nettype none
module a85_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  output logic          push_o,
  output a85_pkg::job_t job_o,
  input  logic          job_ready_i
);
  import a85_pkg::*;

  logic [31:0] group_q, group_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        inmsg_q, inmsg_d;

  logic        accept;
  logic        open_f;
  logic [31:0] base;
  logic [31:0] newv;
  logic [2:0]  k;
  logic        full;

  assign ready_o = job_ready_i;
  assign accept  = valid_i && job_ready_i;
  assign open_f  = !inmsg_q;
  assign base    = open_f ? 32'd0 : group_q;
  assign newv    = {base[23:0], data_i};
  assign k       = {1'b0, (open_f ? 2'd0 : cnt_q)} + 3'd1;
  assign full    = (k == 3'(GroupBytes));

  always_comb begin
    job_o.open_f  = open_f;
    job_o.close_f = last_i;
    job_o.kind    = K_NONE;
    job_o.cnt     = 3'(GroupDigits);
    job_o.value   = newv;
    group_d       = group_q;
    cnt_d         = cnt_q;
    inmsg_d       = inmsg_q;
    if (full) begin
      job_o.kind = (newv == 32'd0) ? K_ZERO : K_DIGITS;
      group_d    = 32'd0;
      cnt_d      = 2'd0;
    end else begin
      group_d = newv;
      cnt_d   = k[1:0];
      if (last_i) begin
        job_o.kind = K_DIGITS;
        job_o.cnt  = k + 3'd1;
        case (k[1:0])
          2'd1:    job_o.value = {newv[7:0], 24'd0};
          2'd2:    job_o.value = {newv[15:0], 16'd0};
          2'd3:    job_o.value = {newv[23:0], 8'd0};
          default: job_o.value = newv;
        endcase
      end
    end
    if (last_i) begin
      inmsg_d = 1'b0;
      group_d = 32'd0;
      cnt_d   = 2'd0;
    end else begin
      inmsg_d = 1'b1;
    end
  end

  assign push_o = accept && (open_f || (job_o.kind != K_NONE) || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= 32'd0;
      cnt_q   <= 2'd0;
      inmsg_q <= 1'b0;
    end else if (accept) begin
      group_q <= group_d;
      cnt_q   <= cnt_d;
      inmsg_q <= inmsg_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/a85_fifo.sv =====
`default_nettype none
module a85_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  a85_pkg::job_t job_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_i,
  output a85_pkg::job_t job_o
);
  import a85_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign ready_o = (cnt_q != CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue count beyond depth");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");
`endif

endmodule
`default_nettype wire

// ===== src/a85_conv.sv =====
`default_nettype none
module a85_conv (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  a85_pkg::job_t job_i,
  output logic          job_pop_o,
  output logic          pkt_valid_o,
  output a85_pkg::pkt_t pkt_o,
  input  logic          pkt_take_i
);
  import a85_pkg::*;

  conv_state_e state_q, state_d;
  pkt_t        pkt_q, pkt_d;
  logic [31:0] value_q, value_d;
  logic [2:0]  step_q, step_d;

  logic [63:0]            prod;
  logic [63-RecipShift:0] quot;
  logic [6:0]             rem7;
  logic [6:0]             dig_char;
  logic [2:0]             idx;
  logic                   load_ok;
  conv_state_e            load_state;

  assign prod     = {32'd0, value_q} * {32'd0, RecipBase};
  assign quot     = prod[63:RecipShift];
  assign rem7     = value_q[6:0] - 7'(quot[6:0] * Base);
  assign dig_char = rem7 + CharOffset;
  assign idx      = 3'(GroupDigits - 1) - step_q;

  assign load_ok     = (state_q == C_IDLE) || ((state_q == C_DONE) && pkt_take_i);
  assign job_pop_o   = load_ok && job_valid_i;
  assign load_state  = (job_i.kind == K_DIGITS) ? C_CALC : C_DONE;
  assign pkt_valid_o = (state_q == C_DONE);
  assign pkt_o       = pkt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      C_IDLE: begin
        if (job_valid_i) begin
          state_d = load_state;
        end
      end
      C_CALC: begin
        if (step_q == 3'(GroupDigits - 1)) begin
          state_d = C_DONE;
        end
      end
      C_DONE: begin
        if (pkt_take_i) begin
          state_d = job_valid_i ? load_state : C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  always_comb begin
    pkt_d   = pkt_q;
    value_d = value_q;
    step_d  = step_q;
    if (job_pop_o) begin
      pkt_d.open_f  = job_i.open_f;
      pkt_d.close_f = job_i.close_f;
      pkt_d.kind    = job_i.kind;
      pkt_d.cnt     = job_i.cnt;
      value_d       = job_i.value;
      step_d        = 3'd0;
    end else if (state_q == C_CALC) begin
      pkt_d.digits[idx] = dig_char;
      value_d           = 32'(quot);
      step_d            = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q   <= pkt_d;
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      step_q  <= 3'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_CALC) |-> (step_q < 3'(GroupDigits)))
    else $error("digit step out of range");
`endif

endmodule
`default_nettype wire

// ===== src/a85_emit.sv =====
`default_nettype none
module a85_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pkt_valid_i,
  input  a85_pkg::pkt_t pkt_i,
  output logic          pkt_take_o,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [6:0]    char_o,
  output logic          last_o
);
  import a85_pkg::*;

  emit_state_e state_q, state_d;
  pkt_t        pkt_q, pkt_d;
  logic [2:0]  didx_q, didx_d;
  logic        valid_q, valid_d;
  logic [6:0]  char_q, char_d;
  logic        last_q, last_d;

  logic        can_emit;
  logic        emit;
  logic        body_end;
  logic        pkt_end;
  logic        take;
  emit_state_e first_state;
  logic [6:0]  char_cur;
  logic        last_cur;

  assign can_emit = !valid_q || ready_i;
  assign emit     = (state_q != E_IDLE) && can_emit;
  assign body_end = (pkt_q.kind == K_ZERO) || (didx_q == pkt_q.cnt - 3'd1);
  assign pkt_end  = (state_q == E_CLOSE1)
                 || (!pkt_q.close_f && (((state_q == E_BODY) && body_end)
                 || ((state_q == E_OPEN1) && (pkt_q.kind == K_NONE))));
  assign take        = (state_q == E_IDLE) || (emit && pkt_end);
  assign pkt_take_o  = take;
  assign first_state = pkt_i.open_f ? E_OPEN0 :
                       (pkt_i.kind != K_NONE) ? E_BODY : E_CLOSE0;

  always_comb begin
    state_d = state_q;
    if (take) begin
      state_d = pkt_valid_i ? first_state : E_IDLE;
    end else if (emit) begin
      case (state_q)
        E_OPEN0: state_d = E_OPEN1;
        E_OPEN1: state_d = (pkt_q.kind != K_NONE) ? E_BODY : E_CLOSE0;
        E_BODY:  state_d = body_end ? E_CLOSE0 : E_BODY;
        E_CLOSE0: state_d = E_CLOSE1;
        default: state_d = state_q;
      endcase
    end
  end

  always_comb begin
    last_cur = 1'b0;
    case (state_q)
      E_OPEN0:  char_cur = CharLt;
      E_OPEN1:  char_cur = CharTilde;
      E_BODY:   char_cur = (pkt_q.kind == K_ZERO) ? CharZero : pkt_q.digits[didx_q];
      E_CLOSE0: char_cur = CharTilde;
      E_CLOSE1: begin
        char_cur = CharGt;
        last_cur = 1'b1;
      end
      default:  char_cur = CharLt;
    endcase
  end

  always_comb begin
    pkt_d   = pkt_q;
    didx_d  = didx_q;
    valid_d = valid_q;
    char_d  = char_q;
    last_d  = last_q;
    if (take && pkt_valid_i) begin
      pkt_d  = pkt_i;
      didx_d = 3'd0;
    end else if (emit && (state_q == E_BODY)) begin
      didx_d = didx_q + 3'd1;
    end
    if (can_emit) begin
      valid_d = emit;
      char_d  = char_cur;
      last_d  = last_cur;
    end
  end

  assign valid_o = valid_q;
  assign char_o  = char_q;
  assign last_o  = last_q;

  always_ff @(posedge clk_i) begin
    pkt_q  <= pkt_d;
    char_q <= char_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      didx_q  <= 3'd0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      didx_q  <= didx_d;
      valid_q <= valid_d;
      last_q  <= last_d;
    end
  end

`ifndef SYNTHESIS
  a_last_gt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (char_q == CharGt))
    else $error("last flag on a character other than the closing one");
  a_body_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == E_BODY) |-> (pkt_q.kind != K_NONE))
    else $error("body phase without a group");
`endif

endmodule
`default_nettype wire
